// File: hw/rtl/stopwatch_controller_assert.svh
// Assertion macros for the stopwatch controller.
`ifndef STOPWATCH_CONTROLLER_ASSERT_SVH
`define STOPWATCH_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define SWC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/swc_pkg.sv
package swc_pkg;

  typedef logic [3:0]  func_t;
  typedef logic [2:0]  status_t;
  typedef logic [13:0] count_t;

  localparam func_t FN_TICK    = 4'd0;
  localparam func_t FN_BUTTON1 = 4'd1;
  localparam func_t FN_BUTTON2 = 4'd2;
  localparam func_t FN_PAUSE   = 4'd3;
  localparam func_t FN_STOP    = 4'd4;
  localparam func_t FN_RESUME  = 4'd5;
  localparam func_t FN_START   = 4'd6;
  localparam func_t FN_SET     = 4'd7;
  localparam func_t FN_OTHER   = 4'd8;

  localparam status_t ST_INITIAL = 3'd0;
  localparam status_t ST_PAUSED  = 3'd1;
  localparam status_t ST_RESUMED = 3'd2;
  localparam status_t ST_STOPPED = 3'd3;
  localparam status_t ST_STARTED = 3'd4;

  localparam int unsigned COUNT_LIMIT = 9999;
  localparam logic [7:0]  DOT_BIT     = 8'h80;

  // reciprocal multipliers, exact for counts below 16384
  localparam int unsigned K_DIV10   = 52429;
  localparam int unsigned K_DIV100  = 5243;
  localparam int unsigned K_DIV1000 = 8389;

  function automatic logic [6:0] seg7(input logic [3:0] digit);
    logic [6:0] code;
    case (digit)
      4'd0: code = 7'h3F;
      4'd1: code = 7'h06;
      4'd2: code = 7'h5B;
      4'd3: code = 7'h4F;
      4'd4: code = 7'h66;
      4'd5: code = 7'h6D;
      4'd6: code = 7'h7D;
      4'd7: code = 7'h07;
      4'd8: code = 7'h7F;
      4'd9: code = 7'h6F;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

endpackage

// File: hw/rtl/swc_if.sv
interface swc_in_if;
  logic              valid;
  logic              ready;
  swc_pkg::func_t    func;
  swc_pkg::count_t   set_value;

  modport source (output valid, output func, output set_value, input ready);
  modport sink   (input valid, input func, input set_value, output ready);
endinterface

interface swc_out_if;
  logic              valid;
  logic              ready;
  swc_pkg::count_t   elapsed;
  swc_pkg::status_t  run_status;
  logic              indicator_blue;
  logic [6:0]        seg_ones;
  logic [7:0]        seg_tens;
  logic [6:0]        seg_hundreds;
  logic [6:0]        seg_thousands;

  modport source (output valid, output elapsed, output run_status, output indicator_blue,
                  output seg_ones, output seg_tens, output seg_hundreds,
                  output seg_thousands, input ready);
  modport sink   (input valid, input elapsed, input run_status, input indicator_blue,
                  input seg_ones, input seg_tens, input seg_hundreds,
                  input seg_thousands, output ready);
endinterface

// File: hw/rtl/stopwatch_controller.sv
// Channel   | Dir | Handshake         | Payload
// in_chan   | in  | valid/ready       | func, set_value
// out_chan  | out | valid/ready       | elapsed, run_status, indicator_blue, seg_*
//
// Accepts one request per cycle while in_chan.ready is high; results pass registered stages:
// state update, reciprocal multiplies for the decimal digits, then digit and segment encode.
// Synchronous active-low reset clears status, count, indicator and all stage valids.
// A low out_chan.ready holds the result register; the stages behind it fill and then
// in_chan.ready drops.
module stopwatch_controller (
  input  logic      clk,
  input  logic      rst_n,
  swc_in_if.sink    in_chan,
  swc_out_if.source out_chan
);
  import swc_pkg::*;

  status_t     status_r, status_nxt;
  count_t      elapsed_r, elapsed_nxt;
  logic        indicator_r, indicator_nxt;
  logic        s1_valid_r;

  logic        s2_valid_r;
  count_t      s2_elapsed_r;
  status_t     s2_status_r;
  logic        s2_indicator_r;
  logic [10:0] s2_q10_r;
  logic [7:0]  s2_q100_r;
  logic [4:0]  s2_q1000_r;

  logic        out_valid_r;
  count_t      out_elapsed_r;
  status_t     out_status_r;
  logic        out_indicator_r;
  logic [6:0]  out_ones_r;
  logic [7:0]  out_tens_r;
  logic [6:0]  out_hundreds_r;
  logic [6:0]  out_thousands_r;

  logic        in_acc;
  logic        s2_ready;
  logic        s3_ready;
  logic [14:0] tick_inc;
  logic [29:0] prod10;
  logic [26:0] prod100;
  logic [27:0] prod1000;
  count_t      ones_diff;
  logic [10:0] tens_diff;
  logic [7:0]  hundreds_diff;
  logic [4:0]  thousands_dig;

  assign s3_ready       = !out_valid_r || out_chan.ready;
  assign s2_ready       = !s2_valid_r || s3_ready;
  assign in_chan.ready  = !s1_valid_r || s2_ready;
  assign in_acc         = in_chan.valid && in_chan.ready;

  always_comb begin
    status_nxt    = status_r;
    elapsed_nxt   = elapsed_r;
    indicator_nxt = indicator_r;
    tick_inc      = (status_r == ST_PAUSED) ? {1'b0, elapsed_r} : {1'b0, elapsed_r} + 15'd1;
    case (in_chan.func)
      FN_TICK: begin
        if (status_r == ST_STOPPED || tick_inc > 15'(COUNT_LIMIT)) begin
          elapsed_nxt = '0;
        end else begin
          elapsed_nxt = tick_inc[13:0];
        end
      end
      FN_BUTTON1: begin
        case (status_r)
          ST_RESUMED: begin
            status_nxt    = ST_PAUSED;
            indicator_nxt = 1'b1;
          end
          ST_PAUSED: begin
            status_nxt    = ST_RESUMED;
            indicator_nxt = 1'b0;
          end
          ST_STOPPED: begin
            status_nxt    = status_r;
          end
          default: begin
            status_nxt    = ST_PAUSED;
            indicator_nxt = 1'b1;
          end
        endcase
      end
      FN_BUTTON2: begin
        status_nxt    = (status_r == ST_STOPPED) ? ST_STARTED : ST_STOPPED;
        indicator_nxt = 1'b0;
      end
      FN_PAUSE: begin
        status_nxt = ST_PAUSED;
      end
      FN_STOP: begin
        status_nxt    = ST_STOPPED;
        indicator_nxt = 1'b0;
      end
      FN_RESUME: begin
        status_nxt    = ST_RESUMED;
        indicator_nxt = 1'b0;
      end
      FN_START: begin
        status_nxt    = ST_STARTED;
        indicator_nxt = 1'b0;
      end
      FN_SET: begin
        elapsed_nxt   = in_chan.set_value;
        indicator_nxt = 1'b0;
      end
      FN_OTHER: begin
        indicator_nxt = 1'b0;
      end
      default: begin
        status_nxt = status_r;
      end
    endcase
  end

  // quotients by 10, 100 and 1000
  assign prod10   = 30'(elapsed_r) * 30'(K_DIV10);
  assign prod100  = 27'(elapsed_r) * 27'(K_DIV100);
  assign prod1000 = 28'(elapsed_r) * 28'(K_DIV1000);

  assign ones_diff     = s2_elapsed_r - 14'(s2_q10_r) * 14'd10;
  assign tens_diff     = s2_q10_r - 11'(s2_q100_r) * 11'd10;
  assign hundreds_diff = s2_q100_r - 8'(s2_q1000_r) * 8'd10;
  assign thousands_dig = (s2_q1000_r >= 5'd10) ? s2_q1000_r - 5'd10 : s2_q1000_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= ST_INITIAL;
      elapsed_r   <= '0;
      indicator_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        status_r    <= status_nxt;
        elapsed_r   <= elapsed_nxt;
        indicator_r <= indicator_nxt;
      end
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_elapsed_r   <= elapsed_r;
      s2_status_r    <= status_r;
      s2_indicator_r <= indicator_r;
      s2_q10_r       <= prod10[29:19];
      s2_q100_r      <= prod100[26:19];
      s2_q1000_r     <= prod1000[27:23];
    end
    if (s3_ready && s2_valid_r) begin
      out_elapsed_r   <= s2_elapsed_r;
      out_status_r    <= s2_status_r;
      out_indicator_r <= s2_indicator_r;
      out_ones_r      <= seg7(ones_diff[3:0]);
      out_tens_r      <= {1'b0, seg7(tens_diff[3:0])} | DOT_BIT;
      out_hundreds_r  <= seg7(hundreds_diff[3:0]);
      out_thousands_r <= seg7(thousands_dig[3:0]);
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.elapsed        = out_elapsed_r;
  assign out_chan.run_status     = out_status_r;
  assign out_chan.indicator_blue = out_indicator_r;
  assign out_chan.seg_ones       = out_ones_r;
  assign out_chan.seg_tens       = out_tens_r;
  assign out_chan.seg_hundreds   = out_hundreds_r;
  assign out_chan.seg_thousands  = out_thousands_r;

`include "stopwatch_controller_assert.svh"

  `SWC_ASSERT_NEXT(a_tick_wraps, in_acc && in_chan.func == FN_TICK, elapsed_r <= 14'(COUNT_LIMIT), "tick left count above limit")
  `SWC_ASSERT_NOW(a_blue_paused, indicator_r, status_r == ST_PAUSED, "blue indicator outside paused")
  `SWC_ASSERT_NEXT(a_state_hold, s1_valid_r && !s2_ready, $stable(elapsed_r) && $stable(status_r), "state moved while stalled")
  `SWC_ASSERT_NOW(a_out_source, $rose(out_valid_r), $past(s2_valid_r), "result without a stage-two request")

endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned PRINT_LIMIT = 40;
  localparam func_t FN_FIRST_UNUSED = 4'd9;
  localparam func_t FN_LAST_UNUSED = 4'd15;
  localparam count_t COUNT_ALL_ONES = 14'h3FFF;
  localparam logic [6:0] DIGIT_SEGMENTS [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef struct packed {
    count_t     elapsed;
    status_t    run_status;
    logic       indicator_blue;
    logic [6:0] seg_ones;
    logic [7:0] seg_tens;
    logic [6:0] seg_hundreds;
    logic [6:0] seg_thousands;
  } readout_t;

  logic clk;
  logic rst_n;

  swc_in_if  in_chan ();
  swc_out_if out_chan ();

  stopwatch_controller uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  status_t watch_status;
  count_t  watch_count;
  logic    watch_blue;

  readout_t    pending_readouts [$];
  int unsigned mismatch_count;
  int unsigned requests_sent;
  int unsigned readouts_checked;
  int unsigned count_wraps;
  int unsigned cycle_count;
  int unsigned results_hold_cycles;
  bit          sender_steady;
  bit          receiver_steady;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic readout_t advance_watch(input func_t f, input count_t v);
    readout_t    r;
    int unsigned n;
    case (f)
      FN_TICK: begin
        if (watch_status == ST_STOPPED) begin
          watch_count = '0;
        end else if (watch_status != ST_PAUSED) begin
          watch_count = watch_count + 1'b1;
          if (watch_count == '0) begin
            count_wraps++;
          end
        end
        if (watch_count > COUNT_LIMIT) begin
          watch_count = '0;
          count_wraps++;
        end
      end
      FN_BUTTON1: begin
        if (watch_status == ST_PAUSED) begin
          watch_status = ST_RESUMED;
          watch_blue = 1'b0;
        end else if (watch_status != ST_STOPPED) begin
          watch_status = ST_PAUSED;
          watch_blue = 1'b1;
        end
      end
      FN_BUTTON2: begin
        watch_status = (watch_status == ST_STOPPED) ? ST_STARTED : ST_STOPPED;
        watch_blue = 1'b0;
      end
      FN_PAUSE: begin
        watch_status = ST_PAUSED;
      end
      FN_STOP: begin
        watch_status = ST_STOPPED;
        watch_blue = 1'b0;
      end
      FN_RESUME: begin
        watch_status = ST_RESUMED;
        watch_blue = 1'b0;
      end
      FN_START: begin
        watch_status = ST_STARTED;
        watch_blue = 1'b0;
      end
      FN_SET: begin
        watch_count = v;
        watch_blue = 1'b0;
      end
      FN_OTHER: begin
        watch_blue = 1'b0;
      end
      default: begin
      end
    endcase
    n = 32'(watch_count);
    r.elapsed = watch_count;
    r.run_status = watch_status;
    r.indicator_blue = watch_blue;
    r.seg_ones = DIGIT_SEGMENTS[n % 10];
    r.seg_tens = DOT_BIT | {1'b0, DIGIT_SEGMENTS[(n / 10) % 10]};
    r.seg_hundreds = DIGIT_SEGMENTS[(n / 100) % 10];
    r.seg_thousands = DIGIT_SEGMENTS[(n / 1000) % 10];
    return r;
  endfunction

  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("tb: mismatch in %s at readout %0d (cycle %0d): got %0h, want %0h",
               field, readouts_checked, cycle_count, got, want);
    end
  endtask

  task automatic send_event(input func_t f, input count_t v);
    int unsigned gap;
    gap = pick_gap(sender_steady);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.func <= f;
    in_chan.set_value <= v;
    do @(posedge clk); while (!in_chan.ready);
    pending_readouts.push_back(advance_watch(f, v));
    requests_sent++;
  endtask

  task automatic wait_for_readouts();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_readouts.size() != 0);
  endtask

  task automatic pick_random_event(output func_t f, output count_t v);
    int unsigned r;
    v = count_t'($urandom_range(0, COUNT_ALL_ONES));
    r = $urandom_range(0, 99);
    if (r < 40) begin
      f = FN_TICK;
    end else if (r < 52) begin
      f = FN_BUTTON1;
    end else if (r < 62) begin
      f = FN_BUTTON2;
    end else if (r < 66) begin
      f = FN_PAUSE;
    end else if (r < 70) begin
      f = FN_STOP;
    end else if (r < 75) begin
      f = FN_RESUME;
    end else if (r < 80) begin
      f = FN_START;
    end else if (r < 90) begin
      f = FN_SET;
      r = $urandom_range(0, 5);
      if (r < 2) begin
        v = count_t'($urandom_range(COUNT_LIMIT - 6, COUNT_LIMIT));
      end else if (r == 2) begin
        v = count_t'($urandom_range(COUNT_LIMIT + 1, COUNT_ALL_ONES));
      end
    end else if (r < 94) begin
      f = FN_OTHER;
    end else begin
      f = func_t'($urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED));
    end
  endtask

  always @(posedge clk) begin
    readout_t got;
    readout_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.elapsed = out_chan.elapsed;
      got.run_status = out_chan.run_status;
      got.indicator_blue = out_chan.indicator_blue;
      got.seg_ones = out_chan.seg_ones;
      got.seg_tens = out_chan.seg_tens;
      got.seg_hundreds = out_chan.seg_hundreds;
      got.seg_thousands = out_chan.seg_thousands;
      if (pending_readouts.size() == 0) begin
        report_mismatch("unrequested readout", got.elapsed, 0);
      end else begin
        want = pending_readouts.pop_front();
        if (got.elapsed !== want.elapsed)
          report_mismatch("elapsed", got.elapsed, want.elapsed);
        if (got.run_status !== want.run_status)
          report_mismatch("run_status", got.run_status, want.run_status);
        if (got.indicator_blue !== want.indicator_blue)
          report_mismatch("indicator_blue", got.indicator_blue, want.indicator_blue);
        if (got.seg_ones !== want.seg_ones)
          report_mismatch("seg_ones", got.seg_ones, want.seg_ones);
        if (got.seg_tens !== want.seg_tens)
          report_mismatch("seg_tens", got.seg_tens, want.seg_tens);
        if (got.seg_hundreds !== want.seg_hundreds)
          report_mismatch("seg_hundreds", got.seg_hundreds, want.seg_hundreds);
        if (got.seg_thousands !== want.seg_thousands)
          report_mismatch("seg_thousands", got.seg_thousands, want.seg_thousands);
      end
      readouts_checked++;
    end
  end

  initial begin
    int unsigned gap;
    out_chan.ready = 1'b0;
    forever begin
      if (results_hold_cycles > 0) begin
        out_chan.ready <= 1'b0;
        repeat (results_hold_cycles) @(posedge clk);
        results_hold_cycles = 0;
      end else begin
        gap = pick_gap(receiver_steady);
        if (gap > 0) begin
          out_chan.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("tb: timeout after %0d cycles, %0d readouts outstanding",
             cycle_count, pending_readouts.size());
    $display("tb: FAIL");
    $finish;
  end

  task automatic test_idle_codes();
    send_event(FN_OTHER, '0);
    send_event(FN_TICK, '0);
    send_event(FN_FIRST_UNUSED, COUNT_ALL_ONES);
    send_event(FN_LAST_UNUSED, COUNT_ALL_ONES);
  endtask

  task automatic test_buttons();
    send_event(FN_BUTTON1, '0);
    send_event(FN_TICK, '0);
    send_event(FN_BUTTON1, '0);
    send_event(FN_BUTTON1, '0);
    send_event(FN_BUTTON2, '0);
    send_event(FN_BUTTON1, '0);
    send_event(FN_TICK, '0);
    send_event(FN_BUTTON2, '0);
    send_event(FN_BUTTON1, '0);
  endtask

  task automatic test_commands();
    send_event(FN_PAUSE, '0);
    send_event(FN_STOP, '0);
    send_event(FN_RESUME, '0);
    send_event(FN_START, '0);
    send_event(FN_SET, 14'd1234);
    send_event(FN_OTHER, COUNT_ALL_ONES);
    send_event(FN_PAUSE, '0);
  endtask

  task automatic test_count_limits();
    send_event(FN_START, '0);
    send_event(FN_SET, COUNT_LIMIT);
    send_event(FN_TICK, '0);
    send_event(FN_SET, COUNT_ALL_ONES);
    send_event(FN_PAUSE, '0);
    send_event(FN_TICK, '0);
    send_event(FN_STOP, '0);
    send_event(FN_TICK, '0);
    wait_for_readouts();
  endtask

  task automatic test_random_traffic(input int unsigned items);
    func_t  f;
    count_t v;
    repeat (items) begin
      pick_random_event(f, v);
      send_event(f, v);
    end
  endtask

  task automatic test_steady_stream();
    sender_steady = 1'b1;
    receiver_steady = 1'b1;
    test_random_traffic(40);
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    results_hold_cycles = 80;
    sender_steady = 1'b1;
    test_random_traffic(30);
    sender_steady = 1'b0;
    wait_for_readouts();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.func = FN_TICK;
    in_chan.set_value = '0;
    watch_status = ST_INITIAL;
    watch_count = '0;
    watch_blue = 1'b0;
    mismatch_count = 0;
    requests_sent = 0;
    readouts_checked = 0;
    count_wraps = 0;
    cycle_count = 0;
    results_hold_cycles = 0;
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_codes();
    test_buttons();
    test_commands();
    test_count_limits();
    test_random_traffic(180);
    test_backpressure();
    test_steady_stream();
    test_random_traffic(180);
    wait_for_readouts();
    repeat (10) @(posedge clk);

    $display("tb: %0d requests, %0d readouts checked, %0d count wraps, %0d cycles",
             requests_sent, readouts_checked, count_wraps, cycle_count);
    $display("tb: covered ticks, both buttons, all commands, unused codes and stalls");
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/swc_pkg.sv
hw/rtl/swc_if.sv
hw/rtl/stopwatch_controller.sv
dv/tb.sv
